// ===== hdl/sis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable insertion sorter package
// Shared widths and the control word that the top level broadcasts to every
// cell of the sorting chain.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned TAG_W   = 32;
  localparam int unsigned GRADE_W = 16;

  // Control broadcast to every cell.
  typedef struct packed {
    logic insert;  // a new word is being placed into the chain
    logic shift;   // the chain moves one place towards cell 0 (drain)
  } sis_ctrl_t;

endpackage

// ===== hdl/sis_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one record of the sorted chain. On insert it keeps its record, takes
// the new word or takes its left neighbour's record; on drain it takes its
// right neighbour's record.
// ----------------------------------------------------------------------------
module sis_cell
  import sis_pkg::*;
(
  input  logic               clk_i,
  input  sis_ctrl_t          ctrl_i,
  input  logic               occupied_i,
  input  logic [TAG_W-1:0]   new_tag_i,
  input  logic [GRADE_W-1:0] new_grade_i,
  input  logic               left_gt_i,
  input  logic [TAG_W-1:0]   left_tag_i,
  input  logic [GRADE_W-1:0] left_grade_i,
  input  logic [TAG_W-1:0]   right_tag_i,
  input  logic [GRADE_W-1:0] right_grade_i,
  output logic               gt_o,
  output logic [TAG_W-1:0]   tag_o,
  output logic [GRADE_W-1:0] grade_o
);

  logic [TAG_W-1:0]   tag_q,   tag_d;
  logic [GRADE_W-1:0] grade_q, grade_d;

  // An empty cell counts as larger than any key. The strict compare keeps
  // equal grades in arrival order.
  assign gt_o = !occupied_i || (grade_q > new_grade_i);

  // Next content of the cell.
  always_comb begin
    tag_d   = tag_q;
    grade_d = grade_q;
    if (ctrl_i.shift) begin
      tag_d   = right_tag_i;
      grade_d = right_grade_i;
    end else if (ctrl_i.insert && gt_o) begin
      if (left_gt_i) begin
        tag_d   = left_tag_i;
        grade_d = left_grade_i;
      end else begin
        tag_d   = new_tag_i;
        grade_d = new_grade_i;
      end
    end
  end

  // Record storage; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    grade_q <= grade_d;
  end

  assign tag_o   = tag_q;
  assign grade_o = grade_q;

endmodule

// ===== hdl/stable_insertion_sorter.sv =====
`timescale 1ns / 1ps
// Insertion: a record is placed in the chain in the cycle it is accepted. For a
//   record marked last, acceptance starts the drain into the result register.
// Throughput: one record per cycle while a set is gathered; a set of n stored
//   records then drains one result per cycle, with busy high.
// Reset clears the fill count, the overflow flag and the drain control; the
//   cell contents are not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Stable insertion sorter
// A chain of cells kept in ascending grade order. Each accepted record is
// inserted unless the chain is full; a last record starts a drain of the whole chain.
// ----------------------------------------------------------------------------
module stable_insertion_sorter
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [TAG_W-1:0]   record_tag_i,
  input  logic [GRADE_W-1:0] grade_i,
  input  logic               last_record_i,
  output logic               out_valid_o,
  output logic [TAG_W-1:0]   out_tag_o,
  output logic [GRADE_W-1:0] out_grade_o,
  output logic               end_of_run_o,
  output logic               dropped_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] fill_q,   fill_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic             ovf_q,    ovf_d;
  logic             drain_q,  drain_d;
  logic             run_drop_q, run_drop_d;

  logic             out_valid_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [GRADE_W-1:0] out_grade_q;
  logic             out_end_q;
  logic             out_drop_q;

  logic      full;
  logic      accept;
  logic      do_insert;
  sis_ctrl_t ctrl;

  logic [CAPACITY-1:0] gt;
  logic [TAG_W-1:0]    cell_tag   [CAPACITY];
  logic [GRADE_W-1:0]  cell_grade [CAPACITY];

  // Handshake and chain control.
  assign busy        = drain_q;
  assign full        = (fill_q == CNT_W'(CAPACITY));
  assign accept      = start && !busy;
  assign do_insert   = accept && !full;
  assign ctrl.insert = do_insert;
  assign ctrl.shift  = drain_q;

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_gt;
    logic [TAG_W-1:0]   left_tag,  right_tag;
    logic [GRADE_W-1:0] left_grade, right_grade;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_tag   = '0;
      assign left_grade = '0;
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_tag   = cell_tag[i-1];
      assign left_grade = cell_grade[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_tag   = '0;
      assign right_grade = '0;
    end else begin : g_inner
      assign right_tag   = cell_tag[i+1];
      assign right_grade = cell_grade[i+1];
    end

    sis_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CNT_W'(i) < fill_q),
      .new_tag_i     (record_tag_i),
      .new_grade_i   (grade_i),
      .left_gt_i     (left_gt),
      .left_tag_i    (left_tag),
      .left_grade_i  (left_grade),
      .right_tag_i   (right_tag),
      .right_grade_i (right_grade),
      .gt_o          (gt[i]),
      .tag_o         (cell_tag[i]),
      .grade_o       (cell_grade[i])
    );
  end

  // Fill count, overflow and drain sequencing.
  always_comb begin
    fill_d     = fill_q;
    ovf_d      = ovf_q;
    drain_d    = drain_q;
    remain_d   = remain_q;
    run_drop_d = run_drop_q;
    if (drain_q) begin
      remain_d = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        drain_d = 1'b0;
        fill_d  = '0;
        ovf_d   = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        fill_d = fill_q + CNT_W'(1);
      end
      if (last_record_i) begin
        drain_d    = 1'b1;
        remain_d   = fill_q + CNT_W'(do_insert);
        run_drop_d = ovf_q || full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      drain_q     <= 1'b0;
      remain_q    <= '0;
      run_drop_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      drain_q     <= drain_d;
      remain_q    <= remain_d;
      run_drop_q  <= run_drop_d;
      out_valid_q <= drain_q;
    end
  end

  // Result register, loaded from the head of the chain while draining.
  always_ff @(posedge clk_i) begin
    if (drain_q) begin
      out_tag_q   <= cell_tag[0];
      out_grade_q <= cell_grade[0];
      out_end_q   <= (remain_q == CNT_W'(1));
      out_drop_q  <= run_drop_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_tag_o    = out_tag_q;
  assign out_grade_o  = out_grade_q;
  assign end_of_run_o = out_valid_q && out_end_q;
  assign dropped_o    = out_drop_q;

  // A drain never runs with nothing left to send.
  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (remain_q != '0))
    else $error("drain active with zero records left");

  // The fill count never passes the chain length.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // An accepted last record always starts a drain.
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_record_i) |=> drain_q)
    else $error("last record did not start a drain");

  // When the final word is shown the set state has been emptied.
  a_run_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |-> (fill_q == '0 && !ovf_q && !drain_q))
    else $error("set state not cleared at end of run");

  // The top cell stays open to any key until the chain is full.
  a_top_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != CNT_W'(CAPACITY)) |-> gt[CAPACITY-1])
    else $error("top cell closed before the chain is full");

endmodule

// ===== tb/sorter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable insertion sorter checker
// Watches the record and result channels of the sorter. Keeps its own sorted
// store, predicts every result word of a set when the last record is taken,
// and compares each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sorter_checker
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [TAG_W-1:0]   record_tag_i,
  input  logic [GRADE_W-1:0] grade_i,
  input  logic               last_record_i,
  input  logic               out_valid_i,
  input  logic [TAG_W-1:0]   out_tag_i,
  input  logic [GRADE_W-1:0] out_grade_i,
  input  logic               end_of_run_i,
  input  logic               dropped_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [GRADE_W-1:0] grade;
    logic               end_of_run;
    logic               dropped;
  } sorted_word_t;

  logic [GRADE_W-1:0] grade_store [CAPACITY];
  logic [TAG_W-1:0]   tag_store [CAPACITY];
  int unsigned        held_count;
  logic               overflow_flag;
  sorted_word_t       expected_words [$];
  int unsigned        mismatches = 0;

  // Places a record after every held record whose grade is not above its own,
  // so equal grades stay in arrival order. A full store drops the record.
  task automatic file_record(input logic [TAG_W-1:0] tag, input logic [GRADE_W-1:0] grade);
    int unsigned pos;
    pos = held_count;
    if (held_count >= CAPACITY) begin
      overflow_flag = 1'b1;
    end else begin
      while (pos > 0 && grade_store[pos-1] > grade) begin
        grade_store[pos] = grade_store[pos-1];
        tag_store[pos]   = tag_store[pos-1];
        pos--;
      end
      grade_store[pos] = grade;
      tag_store[pos]   = tag;
      held_count++;
    end
  endtask

  // Turns the whole store into expected result words and empties it.
  task automatic release_set();
    sorted_word_t w;
    for (int unsigned k = 0; k < held_count; k++) begin
      w.tag        = tag_store[k];
      w.grade      = grade_store[k];
      w.end_of_run = (k + 1 == held_count);
      w.dropped    = overflow_flag;
      expected_words.insert(expected_words.size(), w);
    end
    held_count    = 0;
    overflow_flag = 1'b0;
  endtask

  // Compares one result word with the oldest prediction.
  task automatic check_word();
    sorted_word_t want;
    if (expected_words.size() == 0) begin
      $error("Unexpected result word: tag %h, grade %h", out_tag_i, out_grade_i);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      if (out_tag_i !== want.tag) begin
        $error("out_tag mismatch: expected %h, actual %h", want.tag, out_tag_i);
        mismatches++;
      end
      if (out_grade_i !== want.grade) begin
        $error("out_grade mismatch: expected %h, actual %h", want.grade, out_grade_i);
        mismatches++;
      end
      if (end_of_run_i !== want.end_of_run) begin
        $error("end_of_run mismatch: expected %b, actual %b", want.end_of_run, end_of_run_i);
        mismatches++;
      end
      if (dropped_i !== want.dropped) begin
        $error("dropped mismatch: expected %b, actual %b", want.dropped, dropped_i);
        mismatches++;
      end
    end
  endtask

  // Result words are checked before the record taken at the same edge is
  // filed; a new set cannot produce results in the cycle it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count    = 0;
      overflow_flag = 1'b0;
      expected_words.delete();
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (out_valid_i === 1'b1) begin
        check_word();
      end
      if (start_i && busy_i === 1'b0) begin
        file_record(record_tag_i, grade_i);
        if (last_record_i) begin
          release_set();
        end
      end
      pending_o     <= expected_words.size();
      error_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable insertion sorter testbench
// Feeds sets of records to the sorter in random bursts: a few directed sets
// for extreme grades and tags, reversed and presorted order and equal
// grades, then random sets of mixed length, including a full store and sets
// that overflow it. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top
  import sis_pkg::*;
;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned ITEM_TARGET = 410;
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [TAG_W-1:0]   record_tag;
  logic [GRADE_W-1:0] grade;
  logic               last_record;
  logic               out_valid;
  logic [TAG_W-1:0]   out_tag;
  logic [GRADE_W-1:0] out_grade;
  logic               end_of_run;
  logic               dropped;
  int unsigned        error_count;
  int unsigned        pending_words;
  int unsigned        cycle_count = 0;
  int unsigned        records_sent = 0;
  int unsigned        burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  stable_insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .record_tag_i (record_tag),
    .grade_i      (grade),
    .last_record_i(last_record),
    .out_valid_o  (out_valid),
    .out_tag_o    (out_tag),
    .out_grade_o  (out_grade),
    .end_of_run_o (end_of_run),
    .dropped_o    (dropped)
  );

  sorter_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .record_tag_i (record_tag),
    .grade_i      (grade),
    .last_record_i(last_record),
    .out_valid_i  (out_valid),
    .out_tag_i    (out_tag),
    .out_grade_i  (out_grade),
    .end_of_run_i (end_of_run),
    .dropped_i    (dropped),
    .error_count_o(error_count),
    .pending_o    (pending_words)
  );

  // Offers one record and returns once it has been taken. Between bursts the
  // sender usually drops start for a few cycles.
  task automatic send_record(input logic [TAG_W-1:0] tag, input logic [GRADE_W-1:0] key,
                             input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start       <= 1'b1;
    record_tag  <= tag;
    grade       <= key;
    last_record <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    records_sent++;
  endtask

  // Sends one set of random records. Style 0 spreads grades over the whole
  // range, style 1 crowds them onto four values so ties are common, and
  // style 2 sends them in non-rising order so every strictly lower record shifts the store.
  task automatic send_random_set(input int unsigned len, input int unsigned style);
    logic [GRADE_W-1:0] key;
    logic [GRADE_W-1:0] falling;
    falling = '1;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: begin
          key = GRADE_W'($urandom_range(0, 16'hFFFF));
        end
        1: begin
          key = GRADE_W'($urandom_range(0, 3)) << 8;
        end
        default: begin
          falling = falling - GRADE_W'($urandom_range(0, 900));
          key     = falling;
        end
      endcase
      send_record($urandom, key, i + 1 == len);
    end
  endtask

  initial begin
    int unsigned set_no;
    int unsigned set_len;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    record_tag  <= '0;
    grade       <= '0;
    last_record <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-record sets at both extremes.
    send_record(32'h0000_0000, 16'h0000, 1'b1);
    send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b1);

    // Reversed order: every record lands at the bottom of the store.
    send_record(32'h0000_0001, 16'hFFFF, 1'b0);
    send_record(32'h0000_0002, 16'h8000, 1'b0);
    send_record(32'h0000_0003, 16'h0100, 1'b0);
    send_record(32'h0000_0004, 16'h0001, 1'b0);
    send_record(32'h0000_0005, 16'h0000, 1'b1);

    // Equal grades must leave in arrival order, the last record among them.
    send_record(32'hA5A5_0001, 16'h0280, 1'b0);
    send_record(32'h5A5A_0002, 16'h0100, 1'b0);
    send_record(32'hA5A5_0003, 16'h0280, 1'b0);
    send_record(32'h5A5A_0004, 16'h0100, 1'b0);
    send_record(32'hA5A5_0005, 16'h0280, 1'b0);
    send_record(32'hFFFF_0006, 16'h0280, 1'b1);

    // Presorted order: nothing in the store has to move.
    send_record(32'h8000_0000, 16'h0000, 1'b0);
    send_record(32'h7FFF_FFFF, 16'h0001, 1'b0);
    send_record(32'h1234_5678, 16'h7FFF, 1'b0);
    send_record(32'hFEDC_BA98, 16'hFFFE, 1'b0);
    send_record(32'h0F0F_0F0F, 16'hFFFF, 1'b1);

    // Random sets, mostly short. A few have fixed places in the run: one
    // fills the store exactly, one drops only its last record, and one drops
    // several records including the last.
    set_no = 0;
    while (records_sent < ITEM_TARGET) begin
      if (set_no == 3) begin
        set_len = CAPACITY;
      end else if (set_no == 7) begin
        set_len = CAPACITY + 1;
      end else if (set_no == 11) begin
        set_len = CAPACITY + $urandom_range(2, 6);
      end else if ($urandom_range(0, 9) < 7) begin
        set_len = $urandom_range(1, 8);
      end else begin
        set_len = $urandom_range(9, 30);
      end
      send_random_set(set_len, $urandom_range(0, 2));
      set_no++;
    end
    start <= 1'b0;

    // The checker's counts are registered, so look only after the next edge.
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_words == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guards against a hung handshake or missing results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== stable_insertion_sorter.f =====
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/stable_insertion_sorter.sv
tb/sorter_checker.sv
tb/tb_top.sv
